>>> sv/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

	localparam int KEY_BITS      = 32;
	localparam int MAIN_ENTRIES  = 64;
	localparam int STAGE_ENTRIES = 16;

	localparam int MAIN_AW        = $clog2(MAIN_ENTRIES);
	localparam int STAGE_AW       = $clog2(STAGE_ENTRIES);
	localparam int IDX_BITS       = (MAIN_AW > STAGE_AW) ? MAIN_AW : STAGE_AW;
	localparam int MAX_ENTRIES    = (MAIN_ENTRIES > STAGE_ENTRIES) ? MAIN_ENTRIES : STAGE_ENTRIES;
	localparam int CNT_BITS       = $clog2(MAX_ENTRIES + 1);
	localparam int STAGE_CNT_BITS = $clog2(STAGE_ENTRIES + 1);

	typedef logic [KEY_BITS-1:0] key_t;

	typedef struct packed {
		key_t        key;
		logic [31:0] value;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

	typedef enum logic [2:0] {
		OP_BEGIN    = 3'd0,
		OP_PUT      = 3'd1,
		OP_GET      = 3'd2,
		OP_COMMIT   = 3'd3,
		OP_ROLLBACK = 3'd4
	} op_e;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_ACTIVE    = 3'd1,
		STAT_NO_TXN    = 3'd2,
		STAT_NOT_FOUND = 3'd3,
		STAT_FULL      = 3'd4
	} status_e;

	typedef enum logic [2:0] {
		IDLE,
		DECODE,
		SSCAN,
		MSCAN,
		CREAD,
		CLOAD
	} state_e;

	// keep the low KEY_BITS bits of the 32-bit key, zero-extend above 32
	function automatic key_t to_key(input logic [31:0] k);
		logic [63:0] wide;
		wide = {32'd0, k};
		return wide[KEY_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

>>> sv/kvt_ram.sv
`default_nettype none

module kvt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> sv/transactional_key_value_table_top.sv
// Begin, rollback and refused operations answer straight from the decode state.
// Put scans the staging memory; get scans the staging memory (in an open transaction)
// and then the main memory, each as a linear scan at one entry per cycle.
// Commit walks the staging slots and, per staged entry, loads it and scans the main memory.
// One transaction at a time; a new start is taken in the cycle done is shown.
// Reset clears both valid vectors and the open-transaction flag; memories keep contents.
`default_nettype none

module transactional_key_value_table_top import kvt_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [2:0]         opcode,
	input  wire logic [31:0]        key,
	input  wire logic signed [31:0] data_value,
	output logic                    busy,
	output logic                    done,
	output logic [2:0]              status,
	output logic                    found,
	output logic signed [31:0]      read_value
);

	state_e state_q, state_d;

	logic                      txn_open_q;
	logic [MAIN_ENTRIES-1:0]   main_valid_q;
	logic [STAGE_ENTRIES-1:0]  stage_valid_q;

	logic [2:0]                op_q;
	key_t                      key_q;
	logic [31:0]               val_q;

	logic [CNT_BITS-1:0]       idx_q;
	logic [STAGE_CNT_BITS-1:0] slot_q;
	logic                      rd_vld_s1;
	logic [IDX_BITS-1:0]       rd_idx_s1;
	logic                      free_vld_q;
	logic [IDX_BITS-1:0]       free_q;
	logic                      full_q;

	logic                      done_q;
	logic                      found_q;
	status_e                   status_q;
	logic [31:0]               read_value_q;

	logic [ENTRY_BITS-1:0]     s_rd_raw, m_rd_raw;
	entry_t                    s_rdata, m_rdata;

	logic                      s_cur_valid, s_hit, s_last, s_free_now;
	logic                      m_cur_valid, m_hit, m_last, m_free_now;
	logic                      cur_free, free_any, scan_issue;
	logic [IDX_BITS-1:0]       free_slot;

	logic                      accept;
	logic                      fin, fin_found;
	status_e                   fin_status;
	logic [31:0]               fin_value;
	logic                      scan_init, scan_run;
	logic                      s_we, m_we;
	logic [STAGE_AW-1:0]       s_waddr, s_raddr;
	logic [MAIN_AW-1:0]        m_waddr, m_raddr;
	entry_t                    wr_entry;
	logic                      txn_set, txn_clr, stage_clr;
	logic                      slot_clr, slot_inc, load_entry, full_set;

	assign accept = start && !busy;
	assign busy   = (state_q != IDLE);

	assign s_rdata  = entry_t'(s_rd_raw);
	assign m_rdata  = entry_t'(m_rd_raw);
	assign wr_entry = '{key: key_q, value: val_q};

	// compare stage of the scan pipeline
	assign s_cur_valid = stage_valid_q[rd_idx_s1[STAGE_AW-1:0]];
	assign s_hit       = rd_vld_s1 && s_cur_valid && (s_rdata.key == key_q);
	assign s_last      = rd_vld_s1 && (rd_idx_s1 == IDX_BITS'(STAGE_ENTRIES - 1));
	assign s_free_now  = rd_vld_s1 && !s_cur_valid;

	assign m_cur_valid = main_valid_q[rd_idx_s1[MAIN_AW-1:0]];
	assign m_hit       = rd_vld_s1 && m_cur_valid && (m_rdata.key == key_q);
	assign m_last      = rd_vld_s1 && (rd_idx_s1 == IDX_BITS'(MAIN_ENTRIES - 1));
	assign m_free_now  = rd_vld_s1 && !m_cur_valid;

	assign cur_free   = (state_q == SSCAN) ? s_free_now : m_free_now;
	assign free_any   = free_vld_q || cur_free;
	assign free_slot  = free_vld_q ? free_q : rd_idx_s1;
	assign scan_issue = (state_q == SSCAN) ? (idx_q < CNT_BITS'(STAGE_ENTRIES))
	                                       : (idx_q < CNT_BITS'(MAIN_ENTRIES));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			IDLE: begin
				if (start) state_d = DECODE;
			end
			DECODE: begin
				unique case (op_q)
					OP_PUT:    state_d = txn_open_q ? SSCAN : IDLE;
					OP_GET:    state_d = txn_open_q ? SSCAN : MSCAN;
					OP_COMMIT: state_d = txn_open_q ? CREAD : IDLE;
					default:   state_d = IDLE;
				endcase
			end
			SSCAN: begin
				if (s_hit) begin
					state_d = IDLE;
				end else if (s_last) begin
					state_d = (op_q == OP_GET) ? MSCAN : IDLE;
				end
			end
			MSCAN: begin
				if (m_hit || m_last) begin
					state_d = (op_q == OP_COMMIT) ? CREAD : IDLE;
				end
			end
			CREAD: begin
				if (slot_q == STAGE_CNT_BITS'(STAGE_ENTRIES)) begin
					state_d = IDLE;
				end else if (stage_valid_q[slot_q[STAGE_AW-1:0]]) begin
					state_d = CLOAD;
				end
			end
			CLOAD: state_d = MSCAN;
			default: state_d = IDLE;
		endcase
	end

	always_comb begin
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_found  = 1'b0;
		fin_value  = '0;
		scan_init  = 1'b0;
		scan_run   = 1'b0;
		s_we       = 1'b0;
		m_we       = 1'b0;
		s_waddr    = rd_idx_s1[STAGE_AW-1:0];
		m_waddr    = rd_idx_s1[MAIN_AW-1:0];
		s_raddr    = idx_q[STAGE_AW-1:0];
		m_raddr    = idx_q[MAIN_AW-1:0];
		txn_set    = 1'b0;
		txn_clr    = 1'b0;
		stage_clr  = 1'b0;
		slot_clr   = 1'b0;
		slot_inc   = 1'b0;
		load_entry = 1'b0;
		full_set   = 1'b0;
		unique case (state_q)
			IDLE: begin
			end
			DECODE: begin
				unique case (op_q)
					OP_BEGIN: begin
						fin = 1'b1;
						if (txn_open_q) begin
							fin_status = STAT_ACTIVE;
						end else begin
							txn_set   = 1'b1;
							stage_clr = 1'b1;
						end
					end
					OP_PUT: begin
						if (txn_open_q) begin
							scan_init = 1'b1;
						end else begin
							fin        = 1'b1;
							fin_status = STAT_NO_TXN;
						end
					end
					OP_GET: scan_init = 1'b1;
					OP_COMMIT: begin
						if (txn_open_q) begin
							slot_clr = 1'b1;
						end else begin
							fin        = 1'b1;
							fin_status = STAT_NO_TXN;
						end
					end
					OP_ROLLBACK: begin
						fin = 1'b1;
						if (txn_open_q) begin
							txn_clr   = 1'b1;
							stage_clr = 1'b1;
						end else begin
							fin_status = STAT_NO_TXN;
						end
					end
					default: fin = 1'b1;
				endcase
			end
			SSCAN: begin
				scan_run = 1'b1;
				if (s_hit) begin
					fin = 1'b1;
					if (op_q == OP_PUT) begin
						s_we = 1'b1;
					end else begin
						fin_found = 1'b1;
						fin_value = s_rdata.value;
					end
				end else if (s_last) begin
					if (op_q == OP_PUT) begin
						fin = 1'b1;
						if (free_any) begin
							s_we    = 1'b1;
							s_waddr = free_slot[STAGE_AW-1:0];
						end else begin
							fin_status = STAT_FULL;
						end
					end else begin
						// staging missed: fall through to the main table
						scan_init = 1'b1;
					end
				end
			end
			MSCAN: begin
				scan_run = 1'b1;
				if (m_hit) begin
					if (op_q == OP_COMMIT) begin
						m_we = 1'b1;
					end else begin
						fin       = 1'b1;
						fin_found = 1'b1;
						fin_value = m_rdata.value;
					end
				end else if (m_last) begin
					if (op_q == OP_COMMIT) begin
						if (free_any) begin
							m_we    = 1'b1;
							m_waddr = free_slot[MAIN_AW-1:0];
						end else begin
							full_set = 1'b1;
						end
					end else begin
						fin        = 1'b1;
						fin_status = STAT_NOT_FOUND;
					end
				end
			end
			CREAD: begin
				s_raddr = slot_q[STAGE_AW-1:0];
				if (slot_q == STAGE_CNT_BITS'(STAGE_ENTRIES)) begin
					fin        = 1'b1;
					fin_status = full_q ? STAT_FULL : STAT_OK;
					txn_clr    = 1'b1;
					stage_clr  = 1'b1;
				end else if (!stage_valid_q[slot_q[STAGE_AW-1:0]]) begin
					slot_inc = 1'b1;
				end
			end
			CLOAD: begin
				load_entry = 1'b1;
				slot_inc   = 1'b1;
				scan_init  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			txn_open_q    <= 1'b0;
			main_valid_q  <= '0;
			stage_valid_q <= '0;
			done_q        <= 1'b0;
			rd_vld_s1     <= 1'b0;
			free_vld_q    <= 1'b0;
			full_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (txn_set) begin
				txn_open_q <= 1'b1;
			end else if (txn_clr) begin
				txn_open_q <= 1'b0;
			end
			if (stage_clr) begin
				stage_valid_q <= '0;
			end else if (s_we) begin
				stage_valid_q[s_waddr] <= 1'b1;
			end
			if (m_we) begin
				main_valid_q[m_waddr] <= 1'b1;
			end
			if (slot_clr) begin
				full_q <= 1'b0;
			end else if (full_set) begin
				full_q <= 1'b1;
			end
			if (scan_init) begin
				rd_vld_s1  <= 1'b0;
				free_vld_q <= 1'b0;
			end else if (scan_run) begin
				rd_vld_s1 <= scan_issue;
				if (!free_vld_q && cur_free) begin
					free_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode;
			key_q <= to_key(key);
			val_q <= data_value;
		end else if (load_entry) begin
			key_q <= s_rdata.key;
			val_q <= s_rdata.value;
		end
		if (slot_clr) begin
			slot_q <= '0;
		end else if (slot_inc) begin
			slot_q <= slot_q + STAGE_CNT_BITS'(1);
		end
		if (scan_init) begin
			idx_q <= '0;
		end else if (scan_run) begin
			rd_idx_s1 <= idx_q[IDX_BITS-1:0];
			if (scan_issue) begin
				idx_q <= idx_q + CNT_BITS'(1);
			end
			if (!free_vld_q && cur_free) begin
				free_q <= rd_idx_s1;
			end
		end
		if (fin) begin
			status_q     <= fin_status;
			found_q      <= fin_found;
			read_value_q <= fin_value;
		end
	end

	kvt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (STAGE_ENTRIES)
	) u_stage_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (wr_entry),
		.raddr (s_raddr),
		.rdata (s_rd_raw)
	);

	kvt_ram #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (MAIN_ENTRIES)
	) u_main_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (wr_entry),
		.raddr (m_raddr),
		.rdata (m_rd_raw)
	);

	assign done       = done_q;
	assign status     = status_q;
	assign found      = found_q;
	assign read_value = read_value_q;

endmodule

`default_nettype wire

>>> sv/kvt_checker.sv
`default_nettype none

module kvt_checker import kvt_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic [2:0]         status,
	input wire logic               found,
	input wire logic signed [31:0] read_value
);

	// an accepted transaction raises busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a transaction in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> read_value == 32'sd0)
		else $error("nonzero read_value without a hit");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == STAT_OK)
		else $error("hit reported with an error status");

endmodule

bind transactional_key_value_table_top kvt_checker u_kvt_checker (.*);

`default_nettype wire

>>> tb/transactional_key_value_table_top_tb.sv
`timescale 1ns / 1ps

module transactional_key_value_table_top_tb;
	import kvt_pkg::*;

	localparam int          RANDOM_ITEMS = 420;
	localparam int          POOL_SIZE    = 72;
	localparam int          MAX_GAP      = 40;
	localparam int          DRAIN_CYCLES = 200;
	localparam int          LIMIT_CYCLES = 2_500_000;
	localparam logic [2:0]  OPCODE_MAX   = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] key;
		logic [31:0] value;
		int          gap;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [31:0] value;
	} reply_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic [2:0]         opcode     = '0;
	logic [31:0]        key        = '0;
	logic signed [31:0] data_value = '0;
	logic               busy;
	logic               done;
	logic [2:0]         status;
	logic               found;
	logic signed [31:0] read_value;

	transactional_key_value_table_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.opcode     (opcode),
		.key        (key),
		.data_value (data_value),
		.busy       (busy),
		.done       (done),
		.status     (status),
		.found      (found),
		.read_value (read_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the committed and staged tables
	key_t        main_key_mdl [MAIN_ENTRIES];
	logic [31:0] main_val_mdl [MAIN_ENTRIES];
	bit          main_vld_mdl [MAIN_ENTRIES];
	key_t        stage_key_mdl[STAGE_ENTRIES];
	logic [31:0] stage_val_mdl[STAGE_ENTRIES];
	bit          stage_vld_mdl[STAGE_ENTRIES];
	bit          txn_live;

	cmd_t   cmd_q[$];
	reply_t reply_q[$];
	cmd_t   cur_cmd;
	reply_t last_reply;
	reply_t exp_reply;
	int     idle_cnt;
	int     idle_pct;
	int     n_queued;
	int     n_errors;
	int     n_cycles;
	int     n_by_op[5];
	int     n_spare;
	int     n_hits;
	int     n_full;

	function automatic int find_main_slot(key_t k);
		for (int i = 0; i < MAIN_ENTRIES; i++)
			if (main_vld_mdl[i] && main_key_mdl[i] == k)
				return i;
		return -1;
	endfunction

	function automatic int find_stage_slot(key_t k);
		for (int i = 0; i < STAGE_ENTRIES; i++)
			if (stage_vld_mdl[i] && stage_key_mdl[i] == k)
				return i;
		return -1;
	endfunction

	// advance the table model by one command and return its reply
	function automatic reply_t apply_command(cmd_t c);
		reply_t      r;
		logic [63:0] wide;
		key_t        k;
		int          i;
		int          m;
		r.status = STAT_OK;
		r.found  = 1'b0;
		r.value  = '0;
		wide     = {32'd0, c.key};
		k        = wide[KEY_BITS-1:0];
		case (c.op)
			OP_BEGIN: begin
				if (txn_live) begin
					r.status = STAT_ACTIVE;
				end else begin
					txn_live = 1'b1;
					foreach (stage_vld_mdl[j]) stage_vld_mdl[j] = 1'b0;
				end
			end
			OP_PUT: begin
				if (!txn_live) begin
					r.status = STAT_NO_TXN;
				end else begin
					i = find_stage_slot(k);
					if (i < 0) begin
						for (int j = 0; j < STAGE_ENTRIES; j++)
							if (!stage_vld_mdl[j] && i < 0)
								i = j;
						if (i < 0) begin
							r.status = STAT_FULL;
						end else begin
							stage_vld_mdl[i] = 1'b1;
							stage_key_mdl[i] = k;
						end
					end
					if (i >= 0)
						stage_val_mdl[i] = c.value;
				end
			end
			OP_GET: begin
				i = txn_live ? find_stage_slot(k) : -1;
				if (i >= 0) begin
					r.found = 1'b1;
					r.value = stage_val_mdl[i];
				end else begin
					i = find_main_slot(k);
					if (i >= 0) begin
						r.found = 1'b1;
						r.value = main_val_mdl[i];
					end else begin
						r.status = STAT_NOT_FOUND;
					end
				end
			end
			OP_COMMIT: begin
				if (!txn_live) begin
					r.status = STAT_NO_TXN;
				end else begin
					// merge in staging slot order; drop pairs that find no room
					for (int s = 0; s < STAGE_ENTRIES; s++) begin
						if (stage_vld_mdl[s]) begin
							m = find_main_slot(stage_key_mdl[s]);
							if (m < 0) begin
								for (int j = 0; j < MAIN_ENTRIES; j++)
									if (!main_vld_mdl[j] && m < 0)
										m = j;
								if (m >= 0) begin
									main_vld_mdl[m] = 1'b1;
									main_key_mdl[m] = stage_key_mdl[s];
								end
							end
							if (m >= 0)
								main_val_mdl[m] = stage_val_mdl[s];
							else
								r.status = STAT_FULL;
						end
					end
					foreach (stage_vld_mdl[j]) stage_vld_mdl[j] = 1'b0;
					txn_live = 1'b0;
				end
			end
			OP_ROLLBACK: begin
				if (!txn_live) begin
					r.status = STAT_NO_TXN;
				end else begin
					foreach (stage_vld_mdl[j]) stage_vld_mdl[j] = 1'b0;
					txn_live = 1'b0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		n_errors++;
	endtask

	task automatic queue_cmd(logic [2:0] op, logic [31:0] k, logic [31:0] v);
		cmd_t c;
		c.op    = op;
		c.key   = k;
		c.value = v;
		c.gap   = 0;
		while (c.gap < MAX_GAP && $urandom_range(99) < idle_pct)
			c.gap++;
		cmd_q.push_back(c);
		if (op <= OP_ROLLBACK)
			n_queued++;
	endtask

	// driver: present the next transaction once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			opcode     <= '0;
			key        <= '0;
			data_value <= '0;
			idle_cnt   <= 0;
		end else if (!(start && busy)) begin
			if (start) begin
				last_reply = apply_command(cur_cmd);
				reply_q.push_back(last_reply);
				if (cur_cmd.op <= OP_ROLLBACK)
					n_by_op[cur_cmd.op]++;
				else
					n_spare++;
				if (last_reply.found)
					n_hits++;
				if (last_reply.status == STAT_FULL)
					n_full++;
			end
			if (cmd_q.size() != 0 && idle_cnt >= cmd_q[0].gap) begin
				cur_cmd = cmd_q.pop_front();
				start      <= 1'b1;
				opcode     <= cur_cmd.op;
				key        <= cur_cmd.key;
				data_value <= cur_cmd.value;
				idle_cnt   <= 0;
			end else begin
				start    <= 1'b0;
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	// monitor: every done strobe is one reply
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (reply_q.size() == 0) begin
				report_mismatch("reply with nothing outstanding", {29'd0, status}, '0);
			end else begin
				exp_reply = reply_q.pop_front();
				if (status !== exp_reply.status)
					report_mismatch("status", {29'd0, status}, {29'd0, exp_reply.status});
				if (found !== exp_reply.found)
					report_mismatch("found", {31'd0, found}, {31'd0, exp_reply.found});
				if (read_value !== exp_reply.value)
					report_mismatch("read_value", read_value, exp_reply.value);
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d replies outstanding", n_cycles,
				reply_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] key_pool[POOL_SIZE];
		int          idle_plan[4];
		int          first_random;
		int          phase;
		int          n_puts;
		int          base;
		idle_plan = '{0, 70, 29, 70};
		txn_live  = 1'b0;
		foreach (main_vld_mdl[i]) main_vld_mdl[i] = 1'b0;
		foreach (stage_vld_mdl[i]) stage_vld_mdl[i] = 1'b0;
		n_queued = 0;
		n_errors = 0;
		n_cycles = 0;
		n_spare  = 0;
		n_hits   = 0;
		n_full   = 0;
		foreach (n_by_op[i]) n_by_op[i] = 0;

		// directed: refusals, extremes, staging precedence, rollback, ignored opcodes
		idle_pct = 0;
		queue_cmd(OP_GET,      32'h0000_0000, 32'h0);
		queue_cmd(OP_PUT,      32'h0000_0001, 32'h1);
		queue_cmd(OP_COMMIT,   32'h0,         32'h0);
		queue_cmd(OP_ROLLBACK, 32'h0,         32'h0);
		queue_cmd(OP_BEGIN,    32'h0,         32'h0);
		queue_cmd(OP_BEGIN,    32'h0,         32'h0);
		queue_cmd(OP_PUT,      32'h0000_0000, 32'h8000_0000);
		queue_cmd(OP_PUT,      32'hFFFF_FFFF, 32'h7FFF_FFFF);
		queue_cmd(OP_PUT,      32'h0000_0000, 32'h1234_5678);
		queue_cmd(OP_GET,      32'h0000_0000, 32'h0);
		queue_cmd(OP_GET,      32'hFFFF_FFFF, 32'h0);
		queue_cmd(OP_GET,      32'h5A5A_5A5A, 32'h0);
		queue_cmd(OP_COMMIT,   32'h0,         32'h0);
		queue_cmd(OP_GET,      32'hFFFF_FFFF, 32'h0);
		queue_cmd(OP_BEGIN,    32'h0,         32'h0);
		queue_cmd(OP_PUT,      32'h0000_0000, 32'hFFFF_FFFF);
		queue_cmd(OP_GET,      32'h0000_0000, 32'h0);
		queue_cmd(OP_ROLLBACK, 32'h0,         32'h0);
		queue_cmd(OP_GET,      32'h0000_0000, 32'h0);
		for (int op = OP_ROLLBACK + 1; op <= OPCODE_MAX; op++)
			queue_cmd(op[2:0], $urandom(), $urandom());
		queue_cmd(OP_BEGIN,    32'h0,         32'h0);
		queue_cmd(OP_PUT,      32'hA5A5_A5A5, 32'h0000_0000);
		queue_cmd(OP_COMMIT,   32'h0,         32'h0);

		// key pool a little larger than the main table so that it fills up
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		first_random = n_queued;
		while (n_queued < first_random + RANDOM_ITEMS) begin
			phase = (n_queued - first_random) * 4 / RANDOM_ITEMS;
			if (phase > 3)
				phase = 3;
			idle_pct = idle_plan[phase];
			if ($urandom_range(99) < 80) begin
				queue_cmd(OP_BEGIN, $urandom(), $urandom());
				// now and then a long run of distinct keys to overflow staging
				if ($urandom_range(7) == 0) begin
					n_puts = $urandom_range(STAGE_ENTRIES + 1, STAGE_ENTRIES + 6);
					base   = $urandom_range(POOL_SIZE - 1);
					for (int j = 0; j < n_puts; j++)
						queue_cmd(OP_PUT, key_pool[(base + j) % POOL_SIZE], $urandom());
				end else begin
					n_puts = $urandom_range(1, 10);
					for (int j = 0; j < n_puts; j++) begin
						queue_cmd(OP_PUT, key_pool[$urandom_range(POOL_SIZE - 1)], $urandom());
						if ($urandom_range(2) == 0)
							queue_cmd(OP_GET, key_pool[$urandom_range(POOL_SIZE - 1)],
								$urandom());
						if ($urandom_range(19) == 0)
							queue_cmd(OP_BEGIN, $urandom(), $urandom());
					end
				end
				if ($urandom_range(3) == 0)
					queue_cmd(OP_ROLLBACK, $urandom(), $urandom());
				else
					queue_cmd(OP_COMMIT, $urandom(), $urandom());
				repeat ($urandom_range(3))
					queue_cmd(OP_GET, key_pool[$urandom_range(POOL_SIZE - 1)], $urandom());
			end else begin
				queue_cmd(3'($urandom_range(OPCODE_MAX)),
					$urandom_range(1) ? $urandom() : key_pool[$urandom_range(POOL_SIZE - 1)],
					$urandom());
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || start || reply_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d begin, %0d put, %0d get, %0d commit, %0d rollback, %0d unused",
			n_by_op[OP_BEGIN], n_by_op[OP_PUT], n_by_op[OP_GET], n_by_op[OP_COMMIT],
			n_by_op[OP_ROLLBACK], n_spare);
		$display("lookups that hit: %0d, table-full replies: %0d, mismatches: %0d",
			n_hits, n_full, n_errors);
		if (n_errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
